// ===== rtl/ird_pkg.sv =====
// ============================================================================
// ird_pkg: shared definitions for the indexed ring deque
// Command codes, default sizes and field widths used by the interfaces and
// the deque modules.
// ============================================================================
package ird_pkg;

    // Default geometry of the ring store.
    localparam int DEPTH_DEFAULT      = 1024;
    localparam int WORD_WIDTH_DEFAULT = 32;

    // Width of the command field.
    localparam int CMD_W = 3;

    // Command codes. Codes 6 and 7 carry no meaning and are refused.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_READ       = 3'd4,
        CMD_WRITE      = 3'd5
    } cmd_t;

endpackage

// ===== rtl/ird_if.sv =====
// ============================================================================
// ird_if: command and response channels of the indexed ring deque
// Valid/ready channels; a transaction completes on a rising clock edge at
// which valid and ready are both high.
// ============================================================================

// Command channel: one deque command per transaction.
interface ird_cmd_if #(
    parameter int DEPTH      = ird_pkg::DEPTH_DEFAULT,
    parameter int WORD_WIDTH = ird_pkg::WORD_WIDTH_DEFAULT
);
    localparam int PTR_W = $clog2(DEPTH);

    logic                        valid;
    logic                        ready;
    logic [ird_pkg::CMD_W-1:0]   command;
    logic [PTR_W-1:0]            position;
    logic [WORD_WIDTH-1:0]       item_value;

    modport source (output valid, command, position, item_value, input ready);
    modport sink   (input valid, command, position, item_value, output ready);
endinterface

// Response channel: one result per command.
interface ird_rsp_if #(
    parameter int DEPTH      = ird_pkg::DEPTH_DEFAULT,
    parameter int WORD_WIDTH = ird_pkg::WORD_WIDTH_DEFAULT
);
    localparam int CNT_W = $clog2(DEPTH) + 1;

    logic                        valid;
    logic                        ready;
    logic [WORD_WIDTH-1:0]       read_value;
    logic [CNT_W-1:0]            entry_count;
    logic                        error;

    modport source (output valid, read_value, entry_count, error, input ready);
    modport sink   (input valid, read_value, entry_count, error, output ready);
endinterface

// ===== rtl/indexed_ring_deque.sv =====
// ============================================================================
// indexed_ring_deque: double-ended queue with indexed access
// Pushes and pops at either end, reads or overwrites by logical index, all
// in one circular store located by a front pointer and an entry count.
// ============================================================================
//
//  Channel  Direction  Transaction carries
//  -------  ---------  ------------------------------------------------
//  cmd      in         command, position, item_value
//  rsp      out        read_value, entry_count, error
//
// A command may be accepted in every cycle unless the response path stalls; its
// response passes the store read register, then the output register.
// Throughput is one command per cycle while the response is not stalled, set by
// the single store port, which serves at most one read or one write per command.
// Reset clears the front pointer, the entry count and all valid flags; store
// contents stay undefined and need no clearing pass.
// A stalled response holds its stage; commands keep flowing until both the
// read stage and the output register are occupied.
// ============================================================================
module indexed_ring_deque #(
    parameter int DEPTH      = ird_pkg::DEPTH_DEFAULT,
    parameter int WORD_WIDTH = ird_pkg::WORD_WIDTH_DEFAULT
) (
    input  logic   clk,
    input  logic   rst_n,
    ird_cmd_if.sink   cmd,
    ird_rsp_if.source rsp
);
    import ird_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

    // Architectural state.
    logic [PTR_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Read stage and output register.
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_data_reg;
    logic             s1_err_reg;
    logic [CNT_W-1:0] s1_count_reg;

    logic                  out_valid_reg;
    logic [WORD_WIDTH-1:0] out_value_reg;
    logic [CNT_W-1:0]      out_count_reg;
    logic                  out_err_reg;

    // Command decode.
    cmd_t             op;
    logic             accept;
    logic             s1_adv;
    logic             err;
    logic             wr_en;
    logic             rd_en;
    logic             is_push_front;
    logic [PTR_W-1:0] offset;
    logic [PTR_W:0]   slot_sum;
    logic [PTR_W-1:0] slot;
    logic [PTR_W-1:0] front_dec;
    logic             full;
    logic             empty;
    logic             pos_bad;
    logic [WORD_WIDTH-1:0] rdata;

    // Handshake.
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !s1_valid_reg || s1_adv;
    assign accept    = cmd.valid && cmd.ready;

    assign op        = cmd_t'(cmd.command);
    assign full      = (count_reg == DEPTH_C);
    assign empty     = (count_reg == '0);
    assign pos_bad   = ({1'b0, cmd.position} >= count_reg);
    assign front_dec = (front_reg == '0) ? LAST_SLOT : front_reg - PTR_W'(1);

    // Per-command decision: error, store access, offset and state update.
    always_comb
    begin
        err           = 1'b0;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        is_push_front = 1'b0;
        offset        = '0;
        front_next    = front_reg;
        count_next    = count_reg;
        unique case (op)
            CMD_PUSH_FRONT:
            begin
                err           = full;
                wr_en         = !full;
                is_push_front = 1'b1;
                if (!full)
                begin
                    front_next = front_dec;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_PUSH_BACK:
            begin
                err    = full;
                wr_en  = !full;
                offset = count_reg[PTR_W-1:0];
                if (!full)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_POP_FRONT:
            begin
                err   = empty;
                rd_en = !empty;
                if (!empty)
                begin
                    front_next = (front_reg == LAST_SLOT) ? '0 : front_reg + PTR_W'(1);
                    count_next = count_reg - CNT_W'(1);
                end
            end
            CMD_POP_BACK:
            begin
                err    = empty;
                rd_en  = !empty;
                offset = PTR_W'(count_reg - CNT_W'(1));
                if (!empty)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            CMD_READ:
            begin
                err    = pos_bad;
                rd_en  = !pos_bad;
                offset = cmd.position;
            end
            CMD_WRITE:
            begin
                err    = pos_bad;
                wr_en  = !pos_bad;
                offset = cmd.position;
            end
            default:
            begin
                err = 1'b1;
            end
        endcase
    end

    // Physical slot: front plus offset, wrapped once; front push: front_dec.
    assign slot_sum = {1'b0, front_reg} + {1'b0, offset};
    always_comb
    begin
        if (is_push_front)
        begin
            slot = front_dec;
        end
        else if (slot_sum >= {1'b0, LAST_SLOT} + (PTR_W+1)'(1))
        begin
            slot = PTR_W'(slot_sum - ((PTR_W+1)'(DEPTH)));
        end
        else
        begin
            slot = slot_sum[PTR_W-1:0];
        end
    end

    ird_store #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_store (
        .clk   (clk),
        .wr_en (accept && wr_en),
        .rd_en (accept && rd_en),
        .addr  (slot),
        .wdata (cmd.item_value),
        .rdata (rdata)
    );

    // Pointer and count update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    // Read stage occupancy.
    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Read stage payload, captured alongside the store read.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_data_reg  <= rd_en;
            s1_err_reg   <= err;
            s1_count_reg <= count_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_value_reg <= s1_data_reg ? rdata : '0;
            out_count_reg <= s1_count_reg;
            out_err_reg   <= s1_err_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_value  = out_value_reg;
    assign rsp.entry_count = out_count_reg;
    assign rsp.error       = out_err_reg;

    // The count never exceeds the ring depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count exceeds depth");

    // A refused command leaves the pointer and count untouched.
    a_err_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        accept && err |=> $stable(front_reg) && $stable(count_reg))
        else $error("refused command changed deque state");

    // A successful push grows the count by one.
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !err && (op == CMD_PUSH_FRONT || op == CMD_PUSH_BACK)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not grow the count");

    // A refused command never returns data.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_err_reg |-> out_value_reg == '0)
        else $error("refused command returned data");

    // A stalled read stage keeps its transaction.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_count_reg))
        else $error("read stage dropped a stalled transaction");

endmodule

// ===== rtl/ird_store.sv =====
// ============================================================================
// ird_store: single-port ring storage
// One access per cycle at a shared address; read data is registered and
// holds until the next read.
// ============================================================================
module ird_store #(
    parameter int DEPTH      = ird_pkg::DEPTH_DEFAULT,
    parameter int WORD_WIDTH = ird_pkg::WORD_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic                          rd_en,
    input  logic [$clog2(DEPTH)-1:0]      addr,
    input  logic [WORD_WIDTH-1:0]         wdata,
    output logic [WORD_WIDTH-1:0]         rdata
);
    import ird_pkg::*;

    logic [WORD_WIDTH-1:0] mem [DEPTH];
    logic [WORD_WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
